// ----- hdl/ssp_pkg.sv -----
// shared types and constants of the scanf specification parser
package ssp_pkg;

    // error codes carried in error_kind
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CONV  = 3'd1;
    localparam logic [2:0] ERR_NUL_SET   = 3'd2;
    localparam logic [2:0] ERR_SET_LONG  = 3'd3;
    localparam logic [2:0] ERR_WIDTH_OVF = 3'd4;

    // length modifier codes
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_H    = 4'd1;
    localparam logic [3:0] LEN_HH   = 4'd2;
    localparam logic [3:0] LEN_L    = 4'd3;
    localparam logic [3:0] LEN_LL   = 4'd4;
    localparam logic [3:0] LEN_BIGL = 4'd5;
    localparam logic [3:0] LEN_J    = 4'd6;
    localparam logic [3:0] LEN_Z    = 4'd7;
    localparam logic [3:0] LEN_T    = 4'd8;

    // characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam int         MAP_BITS  = 256;
    localparam int         WORD_BITS = 64;
    localparam logic [9:0] CNT_MAX   = 10'd1023;

    // one finished spec as handed from the parser to the output stage
    typedef struct packed {
        logic       valid;
        logic       is_set;
        logic [2:0] error_kind;
        logic [9:0] consumed;
        logic       skip;
        logic [15:0] width;
        logic       width_given;
        logic [3:0] length_code;
        logic [7:0] conversion;
    } t_desc;

endpackage

// ----- hdl/scanf_spec_parser_unit.sv -----
// top level of the scanf conversion specification parser
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      i_ch, i_start_req
//  result    out        o_out_valid / i_out_ready    o_error_kind .. o_last
//
// one format character per cycle unless a finished spec waits for the result register:
// a word is held in the input register, and the parse logic updates state and
// fills the result register on the same edge; a plain spec or error gives one
// result word, a closed scanset gives four map words in turn from the result register
// characters that give no result keep flowing while the result side stalls;
// a character that finishes a spec waits only until the result register frees
// synchronous active-low reset clears all control state, no clearing pass
module scanf_spec_parser_unit #(
    parameter int WIDTH_BITS = 16,
    parameter int SET_LIMIT  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_start_req,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_error_kind,
    output logic [9:0]  o_consumed,
    output logic        o_skip,
    output logic [15:0] o_width,
    output logic        o_width_given,
    output logic [3:0]  o_length_code,
    output logic [7:0]  o_conversion,
    output logic [1:0]  o_set_word_index,
    output logic [63:0] o_set_word,
    output logic        o_last
);

    // registered character
    logic                         in_valid;
    logic [7:0]                   in_ch;
    logic                         in_start;

    // parse result and handoff control
    ssp_pkg::t_desc               desc;
    logic [ssp_pkg::MAP_BITS-1:0] map;
    logic                         out_free;
    logic                         step;

    // a character advances unless it finishes a spec and the result register is busy
    assign step = in_valid && (!desc.valid || out_free);

    ssp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_ch        (i_ch),
        .i_start_req (i_start_req),
        .i_take      (step),
        .o_valid     (in_valid),
        .o_ch        (in_ch),
        .o_start_req (in_start)
    );

    ssp_parse #(
        .WIDTH_BITS (WIDTH_BITS),
        .SET_LIMIT  (SET_LIMIT)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ch        (in_ch),
        .i_start_req (in_start),
        .o_desc      (desc),
        .o_map       (map)
    );

    // result register, loaded only by a character that finishes a spec
    ssp_out_seq u_out_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (step && desc.valid),
        .i_desc           (desc),
        .i_map            (map),
        .o_free           (out_free),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_error_kind     (o_error_kind),
        .o_consumed       (o_consumed),
        .o_skip           (o_skip),
        .o_width          (o_width),
        .o_width_given    (o_width_given),
        .o_length_code    (o_length_code),
        .o_conversion     (o_conversion),
        .o_set_word_index (o_set_word_index),
        .o_set_word       (o_set_word),
        .o_last           (o_last)
    );

endmodule

// ----- hdl/ssp_in_reg.sv -----
// input register stage holding one format character
module ssp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_start_req,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_ch,
    output logic       o_start_req
);

    logic       r_valid;
    logic [7:0] r_ch;
    logic       r_start_req;

    assign o_ready     = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_ch        = r_ch;
    assign o_start_req = r_start_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch        <= i_ch;
            r_start_req <= i_start_req;
        end
    end

endmodule

// ----- hdl/ssp_parse.sv -----
// parse state and single-pass next-state logic, one character per step
module ssp_parse #(
    parameter int WIDTH_BITS = 16,
    parameter int SET_LIMIT  = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [7:0]                    i_ch,
    input  logic                          i_start_req,
    output ssp_pkg::t_desc                o_desc,
    output logic [ssp_pkg::MAP_BITS-1:0]  o_map
);

    localparam int OFS_MAX = SET_LIMIT + 2;
    localparam int OFS_W   = $clog2(OFS_MAX + 1);
    localparam int VW      = WIDTH_BITS + 4;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_FIRST     = 3'd1;
    localparam logic [2:0] PH_WIDTH     = 3'd2;
    localparam logic [2:0] PH_LEN2      = 3'd3;
    localparam logic [2:0] PH_CONV      = 3'd4;
    localparam logic [2:0] PH_SET_FIRST = 3'd5;
    localparam logic [2:0] PH_SET       = 3'd6;

    logic [2:0]                   r_phase, c_phase, n_phase, ph;
    logic [7:0]                   r_pchar, c_pchar, n_pchar;
    logic                         r_pvalid, c_pvalid, n_pvalid, pv;
    logic                         r_pdash, c_pdash, n_pdash, pd;
    logic [ssp_pkg::MAP_BITS-1:0] r_map, c_map, n_map, base_map, mask, upd_map;
    logic                         r_neg, c_neg, n_neg, base_neg;
    logic [OFS_W-1:0]             r_ofs, c_ofs, n_ofs, ofs;
    logic [WIDTH_BITS-1:0]        r_wacc, c_wacc, n_wacc;
    logic [9:0]                   r_count, c_count, n_count;
    logic                         r_skip, c_skip, n_skip;
    logic                         r_wgiven, c_wgiven, n_wgiven;
    logic [3:0]                   r_len, c_len, n_len;

    logic                         done, elem, in_set, set_caret;
    logic                         emit_one, emit_set, err_on, do_mark, add_dash;
    logic [2:0]                   err;
    logic [7:0]                   lo, hi;
    logic [VW-1:0]                v;
    logic [WIDTH_BITS+15:0]       wide_w;

    function automatic logic is_conv(input logic [7:0] c);
        logic r;
        r = 1'b0;
        case (c)
            "A", "E", "F", "G", "X", "a", "b", "c", "d", "e", "f", "g",
            "i", "n", "o", "p", "s", "u", "v", "x": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // a start request clears the parse state as reset does, but starts in PH_FIRST
    assign c_phase  = i_start_req ? PH_FIRST : r_phase;
    assign c_pchar  = i_start_req ? 8'd0 : r_pchar;
    assign c_pvalid = i_start_req ? 1'b0 : r_pvalid;
    assign c_pdash  = i_start_req ? 1'b0 : r_pdash;
    assign c_map    = i_start_req ? '0 : r_map;
    assign c_neg    = i_start_req ? 1'b0 : r_neg;
    assign c_ofs    = i_start_req ? '0 : r_ofs;
    assign c_wacc   = i_start_req ? '0 : r_wacc;
    assign c_count  = i_start_req ? '0 : r_count;
    assign c_skip   = i_start_req ? 1'b0 : r_skip;
    assign c_wgiven = i_start_req ? 1'b0 : r_wgiven;
    assign c_len    = i_start_req ? ssp_pkg::LEN_NONE : r_len;

    always_comb begin
        n_phase   = c_phase;
        n_pchar   = c_pchar;
        n_pvalid  = c_pvalid;
        n_pdash   = c_pdash;
        n_neg     = c_neg;
        n_ofs     = c_ofs;
        n_wacc    = c_wacc;
        n_count   = c_count;
        n_skip    = c_skip;
        n_wgiven  = c_wgiven;
        n_len     = c_len;
        ph        = c_phase;
        done      = 1'b0;
        elem      = 1'b0;
        in_set    = 1'b0;
        set_caret = 1'b0;
        emit_one  = 1'b0;
        emit_set  = 1'b0;
        err_on    = 1'b0;
        err       = ssp_pkg::ERR_NONE;
        do_mark   = 1'b0;
        add_dash  = 1'b0;
        lo        = c_pchar;
        hi        = c_pchar;
        base_map  = c_map;
        base_neg  = c_neg;
        pv        = c_pvalid;
        pd        = c_pdash;
        ofs       = c_ofs;
        v         = VW'(c_wacc) * VW'(10) + VW'(i_ch[3:0]);

        if (ph == PH_IDLE) begin
            done = 1'b1;
        end else if (c_count != ssp_pkg::CNT_MAX) begin
            n_count = c_count + 10'd1;
        end

        if (!done && ph == PH_FIRST) begin
            n_phase = PH_WIDTH;
            if (i_ch == ssp_pkg::CH_STAR) begin
                n_skip = 1'b1;
                done   = 1'b1;
            end else begin
                ph = PH_WIDTH;
            end
        end

        if (!done && ph == PH_WIDTH) begin
            if (i_ch >= "0" && i_ch <= "9") begin
                done = 1'b1;
                if (v[VW-1:WIDTH_BITS] != 4'd0) begin
                    err_on  = 1'b1;
                    err     = ssp_pkg::ERR_WIDTH_OVF;
                    n_phase = PH_IDLE;
                end else begin
                    n_wacc   = v[WIDTH_BITS-1:0];
                    n_wgiven = 1'b1;
                end
            end else if (i_ch == "h" || i_ch == "l") begin
                n_len   = (i_ch == "h") ? ssp_pkg::LEN_H : ssp_pkg::LEN_L;
                n_phase = PH_LEN2;
                done    = 1'b1;
            end else if (i_ch == "L" || i_ch == "j" || i_ch == "z" || i_ch == "t") begin
                priority case (i_ch)
                    "L":     n_len = ssp_pkg::LEN_BIGL;
                    "j":     n_len = ssp_pkg::LEN_J;
                    "z":     n_len = ssp_pkg::LEN_Z;
                    default: n_len = ssp_pkg::LEN_T;
                endcase
                n_phase = PH_CONV;
                done    = 1'b1;
            end else begin
                n_phase = PH_CONV;
                ph      = PH_CONV;
            end
        end else if (!done && ph == PH_LEN2) begin
            n_phase = PH_CONV;
            if (i_ch == "h" && c_len == ssp_pkg::LEN_H) begin
                n_len = ssp_pkg::LEN_HH;
                done  = 1'b1;
            end else if (i_ch == "l" && c_len == ssp_pkg::LEN_L) begin
                n_len = ssp_pkg::LEN_LL;
                done  = 1'b1;
            end else begin
                ph = PH_CONV;
            end
        end

        if (!done && ph == PH_CONV) begin
            done = 1'b1;
            if (is_conv(i_ch)) begin
                emit_one = 1'b1;
                n_phase  = PH_IDLE;
            end else if (i_ch == ssp_pkg::CH_OPEN) begin
                n_phase = PH_SET_FIRST;
            end else begin
                err_on  = 1'b1;
                err     = ssp_pkg::ERR_BAD_CONV;
                n_phase = PH_IDLE;
            end
        end

        if (!done && (ph == PH_SET_FIRST || ph == PH_SET)) begin
            in_set = 1'b1;
            if (ph == PH_SET_FIRST) begin
                n_phase  = PH_SET;
                n_pvalid = 1'b0;
                n_pdash  = 1'b0;
                pv       = 1'b0;
                pd       = 1'b0;
                if (i_ch == ssp_pkg::CH_CARET) begin
                    set_caret = 1'b1;
                    n_neg     = 1'b1;
                    n_ofs     = OFS_W'(1);
                    done      = 1'b1;
                end else begin
                    base_neg = 1'b0;
                    base_map = '0;
                    n_neg    = 1'b0;
                    ofs      = '0;
                end
            end
        end

        if (!done && in_set) begin
            n_ofs = (ofs != OFS_W'(OFS_MAX)) ? ofs + OFS_W'(1) : ofs;
            if (pv && pd) begin
                do_mark  = 1'b1;
                n_pvalid = 1'b0;
                n_pdash  = 1'b0;
                if (i_ch != ssp_pkg::CH_NUL && i_ch != ssp_pkg::CH_CLOSE) begin
                    hi = i_ch;
                end else if (ofs > OFS_W'(SET_LIMIT + 1)) begin
                    err_on  = 1'b1;
                    err     = ssp_pkg::ERR_SET_LONG;
                    n_phase = PH_IDLE;
                end else begin
                    // trailing dash is literal
                    add_dash = 1'b1;
                    elem     = 1'b1;
                end
            end else if (pv) begin
                if (i_ch == ssp_pkg::CH_DASH) begin
                    n_pdash = 1'b1;
                end else begin
                    do_mark  = 1'b1;
                    n_pvalid = 1'b0;
                    elem     = 1'b1;
                end
            end else begin
                elem = 1'b1;
            end

            if (elem) begin
                if (i_ch == ssp_pkg::CH_CLOSE) begin
                    emit_set = 1'b1;
                    n_phase  = PH_IDLE;
                end else if (ofs > OFS_W'(SET_LIMIT)) begin
                    err_on  = 1'b1;
                    err     = ssp_pkg::ERR_SET_LONG;
                    n_phase = PH_IDLE;
                end else if (i_ch == ssp_pkg::CH_NUL) begin
                    err_on  = 1'b1;
                    err     = ssp_pkg::ERR_NUL_SET;
                    n_phase = PH_IDLE;
                end else begin
                    n_pchar  = i_ch;
                    n_pvalid = 1'b1;
                    n_pdash  = 1'b0;
                end
            end
        end
    end

    // one comparator pair per map bit covers ranges and single marks alike
    always_comb begin
        for (int b = 0; b < ssp_pkg::MAP_BITS; b++) begin
            mask[b] = (do_mark && 8'(b) >= lo && 8'(b) <= hi)
                    || (add_dash && 8'(b) == ssp_pkg::CH_DASH);
        end
    end

    assign upd_map = base_neg ? (base_map & ~mask) : (base_map | mask);
    assign n_map   = set_caret ? '1 : (in_set ? upd_map : c_map);

    assign wide_w = {16'd0, n_wacc};

    always_comb begin
        o_desc             = '0;
        o_desc.valid       = emit_one || emit_set || err_on;
        o_desc.error_kind  = err;
        if (!err_on) begin
            o_desc.is_set      = emit_set;
            o_desc.consumed    = n_count;
            o_desc.skip        = n_skip;
            o_desc.width       = wide_w[15:0];
            o_desc.width_given = n_wgiven;
            o_desc.length_code = n_len;
            o_desc.conversion  = emit_set ? ssp_pkg::CH_OPEN : i_ch;
        end
    end

    assign o_map = upd_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pchar  <= 8'd0;
            r_pvalid <= 1'b0;
            r_pdash  <= 1'b0;
            r_map    <= '0;
            r_neg    <= 1'b0;
            r_ofs    <= '0;
            r_wacc   <= '0;
            r_count  <= '0;
            r_skip   <= 1'b0;
            r_wgiven <= 1'b0;
            r_len    <= ssp_pkg::LEN_NONE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pchar  <= n_pchar;
            r_pvalid <= n_pvalid;
            r_pdash  <= n_pdash;
            r_map    <= n_map;
            r_neg    <= n_neg;
            r_ofs    <= n_ofs;
            r_wacc   <= n_wacc;
            r_count  <= n_count;
            r_skip   <= n_skip;
            r_wgiven <= n_wgiven;
            r_len    <= n_len;
        end
    end

endmodule

// ----- hdl/ssp_out_seq.sv -----
// result register, sends a plain result once or a scanset map as four words
module ssp_out_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  ssp_pkg::t_desc                 i_desc,
    input  logic [ssp_pkg::MAP_BITS-1:0]   i_map,
    output logic                           o_free,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_error_kind,
    output logic [9:0]                     o_consumed,
    output logic                           o_skip,
    output logic [15:0]                    o_width,
    output logic                           o_width_given,
    output logic [3:0]                     o_length_code,
    output logic [7:0]                     o_conversion,
    output logic [1:0]                     o_set_word_index,
    output logic [ssp_pkg::WORD_BITS-1:0]  o_set_word,
    output logic                           o_last
);

    logic                         r_valid;
    ssp_pkg::t_desc               r_desc;
    logic [ssp_pkg::MAP_BITS-1:0] r_map;
    logic [1:0]                   r_idx;
    logic                         last;

    assign last   = !r_desc.is_set || r_idx == 2'd3;
    assign o_free = !r_valid || (i_ready && last);

    assign o_valid          = r_valid;
    assign o_error_kind     = r_desc.error_kind;
    assign o_consumed       = r_desc.consumed;
    assign o_skip           = r_desc.skip;
    assign o_width          = r_desc.width;
    assign o_width_given    = r_desc.width_given;
    assign o_length_code    = r_desc.length_code;
    assign o_conversion     = r_desc.conversion;
    assign o_set_word_index = r_desc.is_set ? r_idx : 2'd0;
    assign o_set_word       = r_desc.is_set ? r_map[r_idx * ssp_pkg::WORD_BITS +:
                                                    ssp_pkg::WORD_BITS] : '0;
    assign o_last           = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_ready) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
            r_map  <= i_map;
        end
    end

endmodule

// ----- tb/tb.sv -----
// testbench of the scanf conversion specification parser, checked against a behavioral predictor
`timescale 1ns / 100ps

module tb;
    import ssp_pkg::*;

    localparam int          FIELD_WIDTH_BITS = 16;
    localparam int          SET_SPAN         = 256;
    localparam int unsigned WIDTH_MAX        = (1 << FIELD_WIDTH_BITS) - 1;
    localparam int          RAND_ITEMS       = 320;
    localparam int          DRAIN_CYCLES     = 20;

    // one result word as seen on the output ports
    typedef struct packed {
        logic [2:0]  err;
        logic [9:0]  consumed;
        logic        skip;
        logic [15:0] width;
        logic        width_given;
        logic [3:0]  len;
        logic [7:0]  conv;
        logic [1:0]  idx;
        logic [63:0] word;
        logic        last;
    } spec_word_t;

    // parser progress inside one spec
    typedef enum logic [2:0] {
        PS_IDLE, PS_FIRST, PS_WIDTH, PS_LEN2, PS_CONV, PS_SET_FIRST, PS_SET
    } parse_state_t;

    // one row of the directed table: head, filler run, tail, optional NUL byte
    typedef struct {
        string      head;
        int         fill;
        logic [7:0] fill_ch;   // CH_NUL here means random set bytes
        string      tail;
        bit         nul_end;
        bit         opens;     // first byte carries start_req
        bit         typed;     // the row's result is typed in below
        spec_word_t want;
    } stim_row_t;

    logic [7:0] conv_letters [20] = '{"A", "E", "F", "G", "X", "a", "b", "c", "d", "e",
                                      "f", "g", "i", "n", "o", "p", "s", "u", "v", "x"};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_ch;
    logic        i_start_req;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_error_kind;
    logic [9:0]  o_consumed;
    logic        o_skip;
    logic [15:0] o_width;
    logic        o_width_given;
    logic [3:0]  o_length_code;
    logic [7:0]  o_conversion;
    logic [1:0]  o_set_word_index;
    logic [63:0] o_set_word;
    logic        o_last;

    scanf_spec_parser_unit #(
        .WIDTH_BITS(FIELD_WIDTH_BITS),
        .SET_LIMIT (SET_SPAN)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_ch            (i_ch),
        .i_start_req     (i_start_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_error_kind    (o_error_kind),
        .o_consumed      (o_consumed),
        .o_skip          (o_skip),
        .o_width         (o_width),
        .o_width_given   (o_width_given),
        .o_length_code   (o_length_code),
        .o_conversion    (o_conversion),
        .o_set_word_index(o_set_word_index),
        .o_set_word      (o_set_word),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // predictor state, a private copy of what the parser holds
    parse_state_t ps_state;
    logic [7:0]   held_ch;
    logic         held;
    logic         held_dash;
    logic [63:0]  member_map [4];
    logic         inverted;
    logic [15:0]  elem_pos;
    int unsigned  width_sum;
    logic [9:0]   char_total;
    logic         sup;
    logic         wid_seen;
    logic [3:0]   len_mod;

    spec_word_t   spec_words_due [$];   // result words still owed by the parser
    stim_row_t    stim_rows [$];
    logic [7:0]   spec_bytes [$];       // bytes of the spec being sent
    spec_word_t   typed_res;
    bit           typed_word;           // rides along with the word it belongs to
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           errors;
    int           depth_was;

    task automatic clear_parse();
        int k;
        ps_state   = PS_IDLE;
        held_ch    = CH_NUL;
        held       = 1'b0;
        held_dash  = 1'b0;
        for (k = 0; k < 4; k++) member_map[k] = '0;
        inverted   = 1'b0;
        elem_pos   = '0;
        width_sum  = 0;
        char_total = '0;
        sup        = 1'b0;
        wid_seen   = 1'b0;
        len_mod    = LEN_NONE;
    endtask

    // an error word carries only its code and the last flag
    task automatic push_word(input logic [2:0] e, input logic [7:0] cv, input logic [1:0] ix,
                             input logic [63:0] wd, input logic lst);
        spec_word_t w;
        w      = '0;
        w.err  = e;
        w.last = lst;
        if (e == ERR_NONE) begin
            w.consumed    = char_total;
            w.skip        = sup;
            w.width       = width_sum[15:0];
            w.width_given = wid_seen;
            w.len         = len_mod;
            w.conv        = cv;
            w.idx         = ix;
            w.word        = wd;
        end
        spec_words_due.push_back(w);
    endtask

    task automatic abort_spec(input logic [2:0] e);
        push_word(e, CH_NUL, 2'd0, 64'd0, 1'b1);
        ps_state = PS_IDLE;
    endtask

    task automatic mark(input logic [7:0] b);
        member_map[b[7:6]][b[5:0]] = !inverted;
    endtask

    function automatic bit is_conv_letter(input logic [7:0] c);
        int i;
        for (i = 0; i < 20; i++)
            if (conv_letters[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    // start of a set element at offset pos, or the closing bracket
    task automatic set_elem(input logic [7:0] c, input int unsigned pos);
        int k;
        if (c == CH_CLOSE) begin
            for (k = 0; k < 4; k++)
                push_word(ERR_NONE, CH_OPEN, k[1:0], member_map[k], k == 3);
            ps_state = PS_IDLE;
            return;
        end
        if (pos > SET_SPAN) begin
            abort_spec(ERR_SET_LONG);
            return;
        end
        if (c == CH_NUL) begin
            abort_spec(ERR_NUL_SET);
            return;
        end
        held_ch   = c;
        held      = 1'b1;
        held_dash = 1'b0;
    endtask

    task automatic set_char(input logic [7:0] c, input int unsigned pos);
        int x;
        if (held && held_dash) begin
            // a range ends here unless the dash turns out to be literal
            if (c != CH_NUL && c != CH_CLOSE) begin
                for (x = held_ch; x <= c; x++) mark(x[7:0]);
                held      = 1'b0;
                held_dash = 1'b0;
                return;
            end
            mark(held_ch);
            held      = 1'b0;
            held_dash = 1'b0;
            if (pos - 1 > SET_SPAN) begin
                abort_spec(ERR_SET_LONG);
                return;
            end
            mark(CH_DASH);
            set_elem(c, pos);
            return;
        end
        if (held) begin
            if (c == CH_DASH) begin
                held_dash = 1'b1;
                return;
            end
            mark(held_ch);
            held = 1'b0;
        end
        set_elem(c, pos);
    endtask

    // advance the predicted parser by one accepted byte
    task automatic parse_char(input logic [7:0] c, input logic st);
        int unsigned pos;
        int unsigned grown;
        int          k;
        if (st) begin
            clear_parse();
            ps_state = PS_FIRST;
        end
        if (ps_state == PS_IDLE) return;
        if (char_total != CNT_MAX) char_total++;

        if (ps_state == PS_FIRST) begin
            ps_state = PS_WIDTH;
            if (c == CH_STAR) begin
                sup = 1'b1;
                return;
            end
        end
        if (ps_state == PS_WIDTH) begin
            if (c >= "0" && c <= "9") begin
                grown = width_sum * 10 + (c - 8'h30);
                if (grown > WIDTH_MAX) begin
                    abort_spec(ERR_WIDTH_OVF);
                    return;
                end
                width_sum = grown;
                wid_seen  = 1'b1;
                return;
            end
            if (c == "h" || c == "l") begin
                len_mod  = (c == "h") ? LEN_H : LEN_L;
                ps_state = PS_LEN2;
                return;
            end
            if (c == "L" || c == "j" || c == "z" || c == "t") begin
                case (c)
                    "L":     len_mod = LEN_BIGL;
                    "j":     len_mod = LEN_J;
                    "z":     len_mod = LEN_Z;
                    default: len_mod = LEN_T;
                endcase
                ps_state = PS_CONV;
                return;
            end
            ps_state = PS_CONV;
        end else if (ps_state == PS_LEN2) begin
            ps_state = PS_CONV;
            if (c == "h" && len_mod == LEN_H) begin
                len_mod = LEN_HH;
                return;
            end
            if (c == "l" && len_mod == LEN_L) begin
                len_mod = LEN_LL;
                return;
            end
        end
        if (ps_state == PS_CONV) begin
            if (is_conv_letter(c)) begin
                push_word(ERR_NONE, c, 2'd0, 64'd0, 1'b1);
                ps_state = PS_IDLE;
            end else if (c == CH_OPEN) begin
                ps_state = PS_SET_FIRST;
            end else begin
                abort_spec(ERR_BAD_CONV);
            end
            return;
        end
        if (ps_state == PS_SET_FIRST) begin
            held      = 1'b0;
            held_dash = 1'b0;
            ps_state  = PS_SET;
            if (c == CH_CARET) begin
                // negated set starts full and elements clear bits
                inverted = 1'b1;
                for (k = 0; k < 4; k++) member_map[k] = '1;
                elem_pos = 16'd1;
                return;
            end
            inverted = 1'b0;
            for (k = 0; k < 4; k++) member_map[k] = '0;
            elem_pos = '0;
        end
        pos = elem_pos;
        if (elem_pos != 16'hFFFF) elem_pos++;
        set_char(c, pos);
    endtask

    function automatic spec_word_t err_word(input logic [2:0] e);
        spec_word_t w;
        w      = '0;
        w.err  = e;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic spec_word_t ok_word(input logic [9:0] n, input logic sk,
                                           input logic [15:0] wd, input logic wg,
                                           input logic [3:0] ln, input logic [7:0] cv);
        spec_word_t w;
        w             = '0;
        w.consumed    = n;
        w.skip        = sk;
        w.width       = wd;
        w.width_given = wg;
        w.len         = ln;
        w.conv        = cv;
        w.last        = 1'b1;
        return w;
    endfunction

    task automatic add_row(input string hd, input int nfill, input logic [7:0] fch,
                           input string tl, input bit nul, input bit opens, input bit tp,
                           input spec_word_t want);
        stim_row_t r;
        r.head    = hd;
        r.fill    = nfill;
        r.fill_ch = fch;
        r.tail    = tl;
        r.nul_end = nul;
        r.opens   = opens;
        r.typed   = tp;
        r.want    = want;
        stim_rows.push_back(r);
    endtask

    // any set byte that is neither NUL, a dash nor a closing bracket
    function automatic logic [7:0] rand_set_byte();
        logic [7:0] b;
        do b = $urandom_range(1, 255);
        while (b == CH_CLOSE || b == CH_DASH);
        return b;
    endfunction

    task automatic add_number(input int unsigned v, input int zeros);
        string s;
        int    i;
        repeat (zeros) spec_bytes.push_back("0");
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++) spec_bytes.push_back(s[i]);
    endtask

    // optional star, width and length modifier
    task automatic add_prefix();
        int unsigned v;
        if ($urandom_range(99) < 30) spec_bytes.push_back(CH_STAR);
        if ($urandom_range(99) < 40) begin
            case ($urandom_range(9))
                0:       v = WIDTH_MAX;
                1, 2, 3: v = $urandom_range(0, WIDTH_MAX);
                default: v = $urandom_range(0, 99);
            endcase
            add_number(v, $urandom_range(0, 2));
        end
        case (4'($urandom_range(0, 8)))
            LEN_H:    spec_bytes.push_back("h");
            LEN_HH:   begin spec_bytes.push_back("h"); spec_bytes.push_back("h"); end
            LEN_L:    spec_bytes.push_back("l");
            LEN_LL:   begin spec_bytes.push_back("l"); spec_bytes.push_back("l"); end
            LEN_BIGL: spec_bytes.push_back("L");
            LEN_J:    spec_bytes.push_back("j");
            LEN_Z:    spec_bytes.push_back("z");
            LEN_T:    spec_bytes.push_back("t");
            default:  ;
        endcase
    endtask

    // one word, with random idle cycles ahead of it; returns at the falling
    // edge after it was taken
    task automatic send_word(input logic [7:0] c, input logic st, input bit tp);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_ch        <= c;
        i_start_req <= st;
        typed_word  <= tp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_spec(input bit opens, input bit tp);
        int i;
        for (i = 0; i < spec_bytes.size(); i++)
            send_word(spec_bytes[i], opens && i == 0, tp && i == spec_bytes.size() - 1);
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // the result side stalls at random
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // prediction on every accepted input word, check on every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                depth_was = spec_words_due.size();
                parse_char(i_ch, i_start_req);
                // a typed row replaces whatever the predictor made of its last byte
                if (typed_word) begin
                    while (spec_words_due.size() > depth_was) void'(spec_words_due.pop_back());
                    spec_words_due.push_back(typed_res);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (spec_words_due.size() == 0) begin
                    $display("%0t: unexpected result word, error_kind %0d conversion %0h",
                             $time, o_error_kind, o_conversion);
                    errors++;
                end else begin
                    typed_res_chk(spec_words_due.pop_front());
                end
            end
        end
    end

    task automatic typed_res_chk(input spec_word_t w);
        cmp_field("error_kind",     w.err,         o_error_kind);
        cmp_field("consumed",       w.consumed,    o_consumed);
        cmp_field("skip",           w.skip,        o_skip);
        cmp_field("width",          w.width,       o_width);
        cmp_field("width_given",    w.width_given, o_width_given);
        cmp_field("length_code",    w.len,         o_length_code);
        cmp_field("conversion",     w.conv,        o_conversion);
        cmp_field("set_word_index", w.idx,         o_set_word_index);
        cmp_field("set_word",       w.word,        o_set_word);
        cmp_field("last",           w.last,        o_last);
    endtask

    initial begin : stimulus
        int          r;
        int          i;
        int          n;
        int          pick;
        int          rand_chars;
        int          letter_turn;
        stim_row_t   row;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_ch        = CH_NUL;
        i_start_req = 1'b0;
        i_out_ready = 1'b0;
        typed_word  = 1'b0;
        typed_res   = '0;
        errors      = 0;
        tx_idle_pct = 37;
        rx_idle_pct = 66;
        rand_chars  = 0;
        letter_turn = $urandom_range(0, 19);
        clear_parse();

        // directed table: plain specs, modifiers, errors, scanset corners
        add_row("d", 0, CH_NUL, "", 0, 1, 1, ok_word(10'd1, 0, 16'd0, 0, LEN_NONE, "d"));
        add_row("abc", 0, CH_NUL, "", 0, 0, 0, '0);    // no start while idle: ignored
        add_row("*65535hhx", 0, CH_NUL, "", 0, 1, 1,
                ok_word(10'd9, 1, 16'd65535, 1, LEN_HH, "x"));
        add_row("65536", 0, CH_NUL, "", 0, 1, 1, err_word(ERR_WIDTH_OVF));
        add_row("0000012lld", 0, CH_NUL, "", 0, 1, 1,
                ok_word(10'd10, 0, 16'd12, 1, LEN_LL, "d"));
        add_row("hd", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("lf", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("Lg", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("jx", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("zu", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("tn", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("*c", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("y", 0, CH_NUL, "", 0, 1, 1, err_word(ERR_BAD_CONV));
        add_row("hy", 0, CH_NUL, "", 0, 1, 1, err_word(ERR_BAD_CONV));
        add_row("*", 0, CH_NUL, "", 1, 1, 1, err_word(ERR_BAD_CONV));
        add_row("\377", 0, CH_NUL, "", 0, 1, 1, err_word(ERR_BAD_CONV));
        // unfinished specs, each cut short by the next start
        add_row("*12", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("5l", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("[ab", 0, CH_NUL, "", 0, 1, 0, '0);
        // leading bracket closes an empty set, plain and negated
        add_row("[]", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("[^]", 0, CH_NUL, "", 0, 1, 0, '0);
        // literal dash, reversed range, ranges above 127
        add_row("[a-]", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("[z-a-]", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("[^\200-\377\001]", 0, CH_NUL, "", 0, 1, 0, '0);
        add_row("[a", 0, CH_NUL, "", 1, 1, 1, err_word(ERR_NUL_SET));
        add_row("[a-", 0, CH_NUL, "", 1, 1, 1, err_word(ERR_NUL_SET));
        // set length right at and just past the limit
        add_row("[", 257, CH_NUL, "]", 0, 1, 0, '0);
        add_row("[", 258, CH_NUL, "", 0, 1, 1, err_word(ERR_SET_LONG));
        add_row("[^", 256, CH_NUL, "]", 0, 1, 0, '0);
        add_row("[^", 257, CH_NUL, "", 0, 1, 1, err_word(ERR_SET_LONG));
        add_row("[", 256, CH_NUL, "-]", 0, 1, 0, '0);
        add_row("[", 257, CH_NUL, "-]", 0, 1, 1, err_word(ERR_SET_LONG));
        // character count saturates
        add_row("", 1030, "0", "d", 0, 1, 1, ok_word(CNT_MAX, 0, 16'd0, 1, LEN_NONE, "d"));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            spec_bytes.delete();
            for (i = 0; i < row.head.len(); i++) spec_bytes.push_back(row.head[i]);
            repeat (row.fill)
                spec_bytes.push_back(row.fill_ch != CH_NUL ? row.fill_ch : rand_set_byte());
            for (i = 0; i < row.tail.len(); i++) spec_bytes.push_back(row.tail[i]);
            if (row.nul_end) spec_bytes.push_back(CH_NUL);
            typed_res = row.want;
            send_spec(row.opens, row.typed);
        end

        // random specs, mostly well formed; idling swaps sides, then stops
        while (rand_chars < RAND_ITEMS) begin
            if (rand_chars >= 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (rand_chars >= RAND_ITEMS / 3) begin
                tx_idle_pct = 66;
                rx_idle_pct = 37;
            end
            spec_bytes.delete();
            pick = $urandom_range(99);
            if (pick < 50) begin
                add_prefix();
                spec_bytes.push_back(conv_letters[letter_turn % 20]);
                letter_turn++;
            end else if (pick < 78) begin
                add_prefix();
                spec_bytes.push_back(CH_OPEN);
                if ($urandom_range(99) < 30) spec_bytes.push_back(CH_CARET);
                n = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 10);
                repeat (n) begin
                    if ($urandom_range(99) < 35) begin
                        spec_bytes.push_back(rand_set_byte());
                        spec_bytes.push_back(CH_DASH);
                        spec_bytes.push_back(rand_set_byte());
                    end else if ($urandom_range(99) < 8) begin
                        spec_bytes.push_back(CH_DASH);
                    end else begin
                        spec_bytes.push_back(rand_set_byte());
                    end
                end
                if ($urandom_range(99) < 15) spec_bytes.push_back(CH_DASH);
                spec_bytes.push_back(($urandom_range(99) < 92) ? CH_CLOSE : CH_NUL);
            end else if (pick < 88) begin
                // noise: any bytes, the spec may be left open
                repeat ($urandom_range(1, 6)) spec_bytes.push_back($urandom_range(0, 255));
            end else if (pick < 95) begin
                case ($urandom_range(2))
                    0: begin
                        add_number($urandom_range(WIDTH_MAX + 1, 99999), $urandom_range(0, 1));
                        spec_bytes.push_back("d");
                    end
                    1: begin
                        spec_bytes.push_back(CH_OPEN);
                        repeat ($urandom_range(0, 3)) spec_bytes.push_back(rand_set_byte());
                        if ($urandom_range(1)) spec_bytes.push_back(CH_DASH);
                        spec_bytes.push_back(CH_NUL);
                    end
                    default: begin
                        add_prefix();
                        spec_bytes.push_back($urandom_range(0, 255));
                    end
                endcase
            end else begin
                // bytes with no start mark, ignored unless an earlier spec is still open
                repeat ($urandom_range(1, 3)) spec_bytes.push_back($urandom_range(0, 255));
                send_spec(0, 0);
                continue;
            end
            send_spec(1, 0);
            rand_chars += spec_bytes.size();
        end
        i_in_valid <= 1'b0;

        // drain, then give a stray word the chance to show up
        while (spec_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
